// ----- hdl/spt_pkg.sv -----
// Shared types and constants for the sorted parameter thinning block.
// Holds the controller state encoding, register indexes and reset values.
// No dependencies.
package spt_pkg;

  localparam int MAX_SAMPLES_DEF = 64;
  localparam int VAL_W           = 32;
  localparam int STEP_W          = 16;
  localparam int SCALE_W         = 17;
  localparam int DIVS_W          = 17;
  localparam int CFG_IDX_W       = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_COUNT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE      = 2'd3;

  localparam logic signed [VAL_W-1:0] RANGE_LOW_RST  = 32'sd0;
  localparam logic signed [VAL_W-1:0] RANGE_HIGH_RST = 32'sd65536;
  localparam logic [STEP_W-1:0]       STEP_COUNT_RST = 16'd2;
  localparam logic [SCALE_W-1:0]      SCALE_RST      = 17'd32768;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SRCH_RD,
    ST_SRCH_CHK,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_INSERT,
    ST_GAP_RD,
    ST_GAP_CHK,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_TOL,
    ST_EMIT_RD,
    ST_EMIT_CHK,
    ST_EMIT_END
  } spt_state_t;

endpackage

// ----- hdl/spt_div.sv -----
// Iterative restoring divider, one quotient bit per cycle.
// Used for the mean gap, the half step and the per-sample width.
// Depends on spt_pkg for the default divisor width.
module spt_div
  import spt_pkg::*;
#(
  parameter int DVD_W = 38,
  parameter int DVS_W = DIVS_W
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVS_W-1:0] rem_r;
  logic [DVD_W-1:0] q_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DVS_W:0]   trial;
  logic             ge;

  // shift in the next dividend bit and try a subtract
  assign trial = {rem_r, q_r[DVD_W-1]};
  assign ge    = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        q_r    <= dividend;
        rem_r  <= '0;
        cnt_r  <= CNT_W'(DVD_W);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= ge ? DVS_W'(trial - {1'b0, divisor}) : trial[DVS_W-1:0];
        q_r   <= {q_r[DVD_W-2:0], ge};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

// ----- hdl/sorted_param_thinning.sv -----
// Sorted parameter thinning: collects a set of Q16.16 values in a sorted
// store and emits a thinned, ascending subset on the last word of a set.
// Depends on spt_pkg and spt_div.
//
// Usage:
//  - in_*: one word per sample value, in_tlast marks the final value of a set.
//  - out_*: one word per kept value, ascending; out_tlast on the final kept
//    value, out_tuser set when a value of that set was dropped (store full).
//  - cfg_*: register writes (range_low, range_high, step_count, scale),
//    always accepted; write only while the block is idle.
// Timing:
//  - Insertion searches the store entry by entry (read state, check state),
//    then shifts the tail entry by entry (read state, write state), as set by
//    the single read port of the memory; no word is accepted until it ends.
//  - On the last word: a gap walk, three divisions on the shared serial
//    divider, one multiply step, then an emission walk over the entries.
// Reset clears the count and drop flag; the memory needs no clearing.
// A stalled receiver holds the emission walk; the output register keeps
// its word until it is taken.
module sorted_param_thinning
  import spt_pkg::*;
#(
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [31:0]          in_tdata,   // [31:0] sample_value
  input  logic                 in_tlast,   // last_sample
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [31:0]          out_tdata,  // [31:0] kept_value
  output logic                 out_tlast,  // last_kept
  output logic                 out_tuser,  // [0] overflowed
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  localparam int AW = $clog2(MAX_SAMPLES);
  localparam int CW = $clog2(MAX_SAMPLES + 1);
  localparam int SW = VAL_W + AW;
  localparam int PW = VAL_W + SCALE_W;
  localparam int TW = PW - 16;

  // value memory
  logic signed [VAL_W-1:0] mem [MAX_SAMPLES];
  logic signed [VAL_W-1:0] rdata_r;
  logic [AW-1:0]           raddr;
  logic [AW-1:0]           waddr;
  logic signed [VAL_W-1:0] wdata;
  logic                    we;

  // configuration
  logic signed [VAL_W-1:0] range_low_r, range_high_r;
  logic [STEP_W-1:0]       step_count_r;
  logic [SCALE_W-1:0]      scale_r;

  // control and datapath
  spt_state_t              state_r, state_nxt;
  logic [CW-1:0]           count_r, count_nxt;
  logic                    drop_r, drop_nxt;
  logic signed [VAL_W-1:0] v_r, v_nxt;
  logic                    last_r, last_nxt;
  logic [CW-1:0]           idx_r, idx_nxt;
  logic [CW-1:0]           pos_r, pos_nxt;
  logic [SW-1:0]           sum_r, sum_nxt;
  logic [CW-1:0]           gaps_r, gaps_nxt;
  logic signed [VAL_W-1:0] prev_r, prev_nxt;
  logic [1:0]              dph_r, dph_nxt;
  logic [VAL_W-1:0]        mean_r, mean_nxt;
  logic [VAL_W-1:0]        half_r, half_nxt;
  logic [VAL_W-1:0]        std_r, std_nxt;
  logic [TW-1:0]           tol_r, tol_nxt;
  logic                    pend_valid_r, pend_valid_nxt;
  logic signed [VAL_W-1:0] pend_r, pend_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic signed [VAL_W-1:0] out_val_r, out_val_nxt;
  logic                    out_last_r, out_last_nxt;
  logic                    out_ovf_r, out_ovf_nxt;

  // divider
  logic                    div_start;
  logic [SW-1:0]           div_dvd;
  logic [DIVS_W-1:0]       div_dvs;
  logic                    div_done;
  logic [SW-1:0]           div_q;

  logic signed [VAL_W:0]   range_d;
  logic [VAL_W-1:0]        width;
  logic [STEP_W-1:0]       steps;
  logic [VAL_W-1:0]        step_max;
  logic [VAL_W:0]          gap;
  logic [VAL_W:0]          kept_gap;
  logic [PW-1:0]           prod;
  logic                    out_free;
  logic                    keep;

  // range width, step count clamp and shared arithmetic
  assign range_d  = {range_high_r[VAL_W-1], range_high_r}
                  - {range_low_r[VAL_W-1], range_low_r};
  assign width    = range_d[VAL_W] ? VAL_W'(-range_d) : range_d[VAL_W-1:0];
  assign steps    = (step_count_r == '0) ? STEP_W'(1) : step_count_r;
  assign step_max = (mean_r > half_r) ? mean_r : half_r;
  assign gap      = {rdata_r[VAL_W-1], rdata_r} - {prev_r[VAL_W-1], prev_r};
  assign kept_gap = {rdata_r[VAL_W-1], rdata_r} - {pend_r[VAL_W-1], pend_r};
  assign prod     = PW'(std_r) * PW'(scale_r);
  assign out_free = !out_valid_r || out_tready;
  assign keep     = !pend_valid_r || (TW'(kept_gap) > tol_r);

  // pick the divide operands for the current phase
  always_comb begin
    case (dph_r)
      2'd0: begin
        div_dvd = (gaps_r == '0) ? '0 : sum_r;
        div_dvs = (gaps_r == '0) ? DIVS_W'(1) : DIVS_W'(gaps_r);
      end
      2'd1: begin
        div_dvd = SW'(width);
        div_dvs = {steps, 1'b0};
      end
      default: begin
        div_dvd = SW'(width);
        div_dvs = DIVS_W'(count_r);
      end
    endcase
  end

  spt_div #(
    .DVD_W(SW),
    .DVS_W(DIVS_W)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(div_dvd),
    .divisor (div_dvs),
    .done    (div_done),
    .quotient(div_q)
  );

  // next state and datapath
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    drop_nxt       = drop_r;
    v_nxt          = v_r;
    last_nxt       = last_r;
    idx_nxt        = idx_r;
    pos_nxt        = pos_r;
    sum_nxt        = sum_r;
    gaps_nxt       = gaps_r;
    prev_nxt       = prev_r;
    dph_nxt        = dph_r;
    mean_nxt       = mean_r;
    half_nxt       = half_r;
    std_nxt        = std_r;
    tol_nxt        = tol_r;
    pend_valid_nxt = pend_valid_r;
    pend_nxt       = pend_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_val_nxt    = out_val_r;
    out_last_nxt   = out_last_r;
    out_ovf_nxt    = out_ovf_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          v_nxt    = in_tdata;
          last_nxt = in_tlast;
          idx_nxt  = '0;
          pos_nxt  = '0;
          state_nxt = (count_r == '0) ? ST_INSERT : ST_SRCH_RD;
        end
      end
      ST_SRCH_RD: state_nxt = ST_SRCH_CHK;
      ST_SRCH_CHK: begin
        if (rdata_r == v_r) begin
          // duplicate: ignore it
          state_nxt = last_r ? ST_GAP_RD : ST_IDLE;
          idx_nxt   = '0;
        end else if (rdata_r > v_r || idx_r + 1'b1 == count_r) begin
          pos_nxt = (rdata_r > v_r) ? idx_r : count_r;
          idx_nxt = count_r;
          if (count_r == CW'(MAX_SAMPLES)) begin
            drop_nxt  = 1'b1;
            state_nxt = last_r ? ST_GAP_RD : ST_IDLE;
            idx_nxt   = '0;
          end else if (count_r == ((rdata_r > v_r) ? idx_r : count_r)) begin
            state_nxt = ST_INSERT;
          end else begin
            state_nxt = ST_SHIFT_RD;
          end
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = ST_SRCH_RD;
        end
      end
      ST_SHIFT_RD: state_nxt = ST_SHIFT_WR;
      ST_SHIFT_WR: begin
        idx_nxt   = idx_r - 1'b1;
        state_nxt = (idx_r - 1'b1 == pos_r) ? ST_INSERT : ST_SHIFT_RD;
      end
      ST_INSERT: begin
        count_nxt = count_r + 1'b1;
        idx_nxt   = '0;
        state_nxt = last_r ? ST_GAP_RD : ST_IDLE;
      end
      ST_GAP_RD: begin
        if (idx_r == '0) begin
          sum_nxt  = '0;
          gaps_nxt = '0;
        end
        state_nxt = ST_GAP_CHK;
      end
      ST_GAP_CHK: begin
        if (idx_r != '0 && gap != '0) begin
          sum_nxt  = sum_r + SW'(gap);
          gaps_nxt = gaps_r + 1'b1;
        end
        prev_nxt = rdata_r;
        idx_nxt  = idx_r + 1'b1;
        dph_nxt  = '0;
        state_nxt = (idx_r + 1'b1 == count_r) ? ST_DIV_GO : ST_GAP_RD;
      end
      ST_DIV_GO: state_nxt = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div_done) begin
          case (dph_r)
            2'd0: begin
              mean_nxt  = div_q[VAL_W-1:0];
              dph_nxt   = 2'd1;
              state_nxt = ST_DIV_GO;
            end
            2'd1: begin
              half_nxt  = div_q[VAL_W-1:0];
              dph_nxt   = 2'd2;
              state_nxt = ST_DIV_GO;
            end
            default: begin
              std_nxt   = (div_q[VAL_W-1:0] > step_max) ? div_q[VAL_W-1:0] : step_max;
              state_nxt = ST_TOL;
            end
          endcase
        end
      end
      ST_TOL: begin
        tol_nxt        = prod[PW-1:16];
        idx_nxt        = '0;
        pend_valid_nxt = 1'b0;
        state_nxt      = ST_EMIT_RD;
      end
      ST_EMIT_RD: state_nxt = ST_EMIT_CHK;
      ST_EMIT_CHK: begin
        if (keep && pend_valid_r && !out_free) begin
          state_nxt = ST_EMIT_CHK;
        end else begin
          if (keep) begin
            if (pend_valid_r) begin
              out_valid_nxt = 1'b1;
              out_val_nxt   = pend_r;
              out_last_nxt  = 1'b0;
              out_ovf_nxt   = drop_r;
            end
            pend_valid_nxt = 1'b1;
            pend_nxt       = rdata_r;
          end
          idx_nxt   = idx_r + 1'b1;
          state_nxt = (idx_r + 1'b1 == count_r) ? ST_EMIT_END : ST_EMIT_RD;
        end
      end
      ST_EMIT_END: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_val_nxt    = pend_r;
          out_last_nxt   = 1'b1;
          out_ovf_nxt    = drop_r;
          pend_valid_nxt = 1'b0;
          count_nxt      = '0;
          drop_nxt       = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // memory ports and handshake outputs
  always_comb begin
    raddr     = idx_r[AW-1:0];
    waddr     = idx_r[AW-1:0];
    wdata     = rdata_r;
    we        = 1'b0;
    div_start = 1'b0;
    case (state_r)
      ST_SHIFT_RD: raddr = AW'(idx_r - 1'b1);
      ST_SHIFT_WR: we = 1'b1;
      ST_INSERT: begin
        we    = 1'b1;
        waddr = pos_r[AW-1:0];
        wdata = v_r;
      end
      ST_DIV_GO: div_start = 1'b1;
      default: ;
    endcase
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_val_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_ovf_r;

  // value memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_low_r  <= RANGE_LOW_RST;
      range_high_r <= RANGE_HIGH_RST;
      step_count_r <= STEP_COUNT_RST;
      scale_r      <= SCALE_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_RANGE_LOW:  range_low_r  <= cfg_data;
        CFG_RANGE_HIGH: range_high_r <= cfg_data;
        CFG_STEP_COUNT: step_count_r <= cfg_data[STEP_W-1:0];
        CFG_SCALE:      scale_r      <= cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      drop_r       <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      dph_r        <= '0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      drop_r       <= drop_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      dph_r        <= dph_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    v_r        <= v_nxt;
    last_r     <= last_nxt;
    idx_r      <= idx_nxt;
    pos_r      <= pos_nxt;
    sum_r      <= sum_nxt;
    gaps_r     <= gaps_nxt;
    prev_r     <= prev_nxt;
    mean_r     <= mean_nxt;
    half_r     <= half_nxt;
    std_r      <= std_nxt;
    tol_r      <= tol_nxt;
    pend_r     <= pend_nxt;
    out_val_r  <= out_val_nxt;
    out_last_r <= out_last_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_SAMPLES))
    else $error("sample count above capacity");

  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    drop_r |-> count_r == CW'(MAX_SAMPLES))
    else $error("drop flag set with free store space");

  a_emit_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT_CHK || state_r == ST_GAP_CHK) |-> !we)
    else $error("store written during a walk");

  a_push_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT_END && out_free) |=> out_valid_r && out_last_r)
    else $error("final kept word not issued");
`endif

endmodule

// ----- dv/sorted_param_thinning_tb.sv -----
// Testbench for sorted_param_thinning: drives sets of Q16.16 samples and
// register writes, predicts the thinned ascending output, checks every word.
// Depends on spt_pkg and the block's RTL.
module sorted_param_thinning_tb;
  import spt_pkg::*;

  typedef struct packed {
    logic [31:0] kept;
    logic        last;
    logic        ovf;
  } kept_word_t;

  // Predictor and queue of expected kept words
  class thin_scoreboard;
    logic signed [31:0] vals[$];
    logic               dropped;
    logic signed [31:0] r_low, r_high;
    logic [15:0]        steps;
    logic [16:0]        scl;
    kept_word_t         pending[$];
    int                 errors;

    function void reset_model();
      vals.delete();
      dropped = 0;
      r_low = RANGE_LOW_RST;
      r_high = RANGE_HIGH_RST;
      steps = STEP_COUNT_RST;
      scl = SCALE_RST;
      pending.delete();
      errors = 0;
    endfunction

    function void note_cfg(logic [CFG_IDX_W-1:0] idx, logic [31:0] d);
      case (idx)
        CFG_RANGE_LOW:  r_low = d;
        CFG_RANGE_HIGH: r_high = d;
        CFG_STEP_COUNT: steps = d[15:0];
        CFG_SCALE:      scl = d[16:0];
        default: ;
      endcase
    endfunction

    function void note_input(logic signed [31:0] v, logic lst);
      int pos;
      longint signed dd;
      longint unsigned width, half, step, stdv, tol, sum, gaps, g, stp;
      logic signed [31:0] lastk;
      int n;
      kept_word_t w;
      pos = 0;
      while (pos < vals.size() && vals[pos] < v) pos++;
      if (!(pos < vals.size() && vals[pos] == v)) begin
        if (vals.size() >= MAX_SAMPLES_DEF) dropped = 1;
        else vals.insert(pos, v);
      end
      if (!lst) return;
      dd = longint'(r_high) - longint'(r_low);
      width = dd < 0 ? -dd : dd;
      stp = (steps == 0) ? 1 : steps;
      sum = 0;
      gaps = 0;
      for (int i = 1; i < vals.size(); i++) begin
        g = longint'(vals[i]) - longint'(vals[i-1]);
        if (g > 0) begin
          sum += g;
          gaps++;
        end
      end
      half = width / (2 * stp);
      step = half;
      if (gaps != 0 && sum / gaps > step) step = sum / gaps;
      stdv = step;
      if (width / vals.size() > stdv) stdv = width / vals.size();
      tol = (stdv * scl) >> 16;
      n = 0;
      lastk = 0;
      foreach (vals[i]) begin
        if (n == 0 || longint'(vals[i]) - longint'(lastk) > tol) begin
          w.kept = vals[i];
          w.last = 0;
          w.ovf = dropped;
          pending.push_back(w);
          lastk = vals[i];
          n++;
        end
      end
      if (n > 0) pending[pending.size()-1].last = 1;
      vals.delete();
      dropped = 0;
    endfunction

    function void check_word(kept_word_t got);
      kept_word_t exp_w;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word %h", got);
        return;
      end
      exp_w = pending.pop_front();
      if (got !== exp_w) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp val %h last %b ovf %b, got val %h last %b ovf %b",
                   exp_w.kept, exp_w.last, exp_w.ovf, got.kept, got.last, got.ovf);
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_tvalid, in_tready, in_tlast;
  logic [31:0] in_tdata;
  logic out_tvalid, out_tready, out_tlast, out_tuser;
  logic [31:0] out_tdata;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0] cfg_data;
  thin_scoreboard sb;
  bit quiet;

  sorted_param_thinning u_top (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Receiver: random stall bursts, check each accepted word
  initial begin
    int stall;
    out_tready = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) sb.check_word({out_tdata, out_tlast, out_tuser});
      if (stall > 0) begin
        stall--;
        out_tready <= 0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(0, 15);
        out_tready <= 0;
      end else out_tready <= 1;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] d);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    sb.note_cfg(idx, d);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  task automatic send_sample(logic [31:0] v, logic lst);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      repeat ($urandom_range(0, 15)) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= v;
    in_tlast <= lst;
    do @(posedge clk); while (!in_tready);
    sb.note_input(v, lst);
    in_tvalid <= 0;
    @(posedge clk);
  endtask

  // Wait for all expected words, then let the block settle
  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  // Random set: mostly clustered values with random spread, some wide noise
  task automatic random_set(int n);
    logic [31:0] base, v;
    base = $urandom;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 3))
        0: v = $urandom;
        1: v = base;
        default: v = base + $urandom_range(0, 1 << $urandom_range(4, 20));
      endcase
      send_sample(v, i == n - 1);
    end
  endtask

  initial begin
    sb = new();
    sb.reset_model();
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = 0;
    in_tlast = 0;
    cfg_valid = 0;
    cfg_index = CFG_RANGE_LOW;
    cfg_data = 0;
    quiet = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: extremes, duplicates, single-value set with reset registers
    send_sample(32'h8000_0000, 0);
    send_sample(32'h7FFF_FFFF, 0);
    send_sample(32'h7FFF_FFFF, 0);
    send_sample(32'h0000_0000, 0);
    send_sample(32'hFFFF_FFFF, 1);
    send_sample(32'h0001_0000, 1);
    drain();
    // Low above high, zero step count, scale at its top
    write_reg(CFG_RANGE_LOW, 32'h7FFF_FFFF);
    write_reg(CFG_RANGE_HIGH, 32'h8000_0000);
    write_reg(CFG_STEP_COUNT, 0);
    write_reg(CFG_SCALE, 32'h1FFFF);
    for (int i = 0; i < 8; i++) send_sample(i * 32'h1000_0000, i == 7);
    drain();
    // Full store plus drops, scale zero keeps every distinct value
    write_reg(CFG_SCALE, 0);
    write_reg(CFG_STEP_COUNT, 16'hFFFF);
    write_reg(CFG_RANGE_LOW, 0);
    write_reg(CFG_RANGE_HIGH, 0);
    for (int i = 0; i < 70; i++) send_sample(70 - i, i == 69);
    drain();

    // Random phases across register settings
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CFG_RANGE_LOW, $urandom);
      write_reg(CFG_RANGE_HIGH, $urandom);
      write_reg(CFG_STEP_COUNT, $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535)
                                                          : $urandom_range(1, 8));
      write_reg(CFG_SCALE, $urandom_range(0, 3) == 0 ? $urandom_range(0, 131071)
                                                     : $urandom_range(0, 65536));
      if (ph == 5) quiet = 1;
      for (int s = 0; s < 2; s++) random_set($urandom_range(1, 4));
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #5000000;
    $display("Regression FAIL");
    $finish;
  end
endmodule

// ----- files.f -----
hdl/spt_pkg.sv
hdl/spt_div.sv
hdl/sorted_param_thinning.sv
dv/sorted_param_thinning_tb.sv
